>>> src/ordered_list_engine_macros.svh
// Assertion macros used by the checker of the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define OLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ordered list engine check failed");

// Consequent holds in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ordered list engine check failed");

`endif

>>> src/ole_pkg.sv
`default_nettype none

package ole_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = 5;  // position and count fields on the ports
  localparam int unsigned DW = 32;

  typedef enum logic [2:0] {
    CMD_SORTED       = 3'd0,
    CMD_PUSH_BACK    = 3'd1,
    CMD_PUSH_FRONT   = 3'd2,
    CMD_INSERT_AFTER = 3'd3,
    CMD_POP_BACK     = 3'd4,
    CMD_POP_FRONT    = 3'd5,
    CMD_REMOVE       = 3'd6,
    CMD_READ         = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_NOPOS = 3'd3,
    ST_MODE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_TAKE,
    S_SHIFT_DN
  } state_e;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic [DW-1:0]        element;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> src/ole_store.sv
`default_nettype none

module ole_store (
  input  logic              clk_i,
  input  ole_pkg::mem_req_t req_i,
  output ole_pkg::entry_t   rdata_o
);
  import ole_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/ole_seq.sv
`default_nettype none

module ole_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode_i,
  input  logic [2:0]               command_i,
  input  logic signed [31:0]       value_i,
  input  logic [31:0]              element_i,
  input  logic [4:0]               position_i,
  output ole_pkg::mem_req_t        mem_req_o,
  input  ole_pkg::entry_t          mem_rdata_i,
  output logic                     done_o,
  output logic [2:0]               status_o,
  output logic signed [31:0]       out_value_o,
  output logic [31:0]              out_element_o,
  output logic [4:0]               out_position_o,
  output logic [4:0]               entry_count_o
);
  import ole_pkg::*;

  state_e        state_q, state_d;
  cmd_e          cmd_q, cmd_d;
  entry_t        new_q, new_d;
  logic [CW-1:0] lim_q, lim_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic          done_q, done_d;
  status_e       status_q, status_d;
  entry_t        res_q, res_d;
  logic [PW-1:0] res_pos_q, res_pos_d;
  logic [PW-1:0] res_count_q, res_count_d;

  cmd_e          cmd_in;
  logic          accept;
  logic          is_ins;
  logic          pos_over;
  status_e       acc_status;
  logic [CW-1:0] ins_lim;
  logic [CW-1:0] take_k;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic          ins_stop;
  logic          last_take;
  logic          last_dn;
  logic [PW-1:0] idx_pos;

  // Command decode and status check, all against the current count.
  always_comb begin
    cmd_in   = cmd_e'(command_i);
    accept   = start && (state_q == S_IDLE);
    is_ins   = (cmd_in == CMD_SORTED) || (cmd_in == CMD_PUSH_BACK) ||
               (cmd_in == CMD_PUSH_FRONT) || (cmd_in == CMD_INSERT_AFTER);
    pos_over = 32'(position_i) > 32'(count_q);
    ins_lim  = '0;
    take_k   = '0;
    case (cmd_in)
      CMD_PUSH_BACK:    ins_lim = count_q;
      CMD_INSERT_AFTER: ins_lim = CW'(position_i);
      default:          ins_lim = '0;
    endcase
    case (cmd_in)
      CMD_POP_BACK:  take_k = count_q - CW'(1);
      CMD_POP_FRONT: take_k = '0;
      default:       take_k = CW'(position_i) - CW'(1);
    endcase
    acc_status = ST_OK;
    if (is_ins) begin
      if (mode_i != (cmd_in == CMD_SORTED)) begin
        acc_status = ST_MODE;
      end else if (count_q == CW'(CAPACITY)) begin
        acc_status = ST_FULL;
      end else if ((cmd_in == CMD_INSERT_AFTER) && pos_over) begin
        acc_status = ST_NOPOS;
      end
    end else if (count_q == '0) begin
      acc_status = ST_EMPTY;
    end else if (((cmd_in == CMD_REMOVE) || (cmd_in == CMD_READ)) &&
                 ((position_i == '0) || pos_over)) begin
      acc_status = ST_NOPOS;
    end
  end

  always_comb begin
    idx_dec   = idx_q - CW'(1);
    idx_inc   = idx_q + CW'(1);
    ins_stop  = (cmd_q == CMD_SORTED) &&
                ($signed(new_q.value) <= $signed(mem_rdata_i.value));
    last_take = (idx_inc == count_q);
    last_dn   = ((idx_q + CW'(2)) == count_q);
    idx_pos   = PW'({1'b0, idx_q} + (CW + 1)'(1));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (acc_status == ST_OK)) begin
          if (!is_ins) begin
            state_d = S_TAKE;
          end else if (count_q == ins_lim) begin
            state_d = S_PUT;
          end else begin
            state_d = S_SHIFT_UP;
          end
        end
      end
      S_SHIFT_UP: begin
        if (ins_stop) begin
          state_d = S_IDLE;
        end else if (idx_dec == lim_q) begin
          state_d = S_PUT;
        end
      end
      S_PUT: state_d = S_IDLE;
      S_TAKE: begin
        if ((cmd_q == CMD_READ) || last_take) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SHIFT_DN;
        end
      end
      S_SHIFT_DN: begin
        if (last_dn) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, store requests and result
  always_comb begin
    cmd_d       = cmd_q;
    new_d       = new_q;
    lim_d       = lim_q;
    idx_d       = idx_q;
    count_d     = count_q;
    done_d      = 1'b0;
    status_d    = status_q;
    res_d       = res_q;
    res_pos_d   = res_pos_q;
    res_count_d = res_count_q;
    mem_req_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_in;
          new_d     = '{value: value_i, element: element_i};
          status_d  = acc_status;
          res_d     = '0;
          res_pos_d = '0;
          if (acc_status != ST_OK) begin
            done_d      = 1'b1;
            res_count_d = PW'(count_q);
          end else if (is_ins) begin
            lim_d           = ins_lim;
            idx_d           = count_q;
            mem_req_o.raddr = AW'(count_q - CW'(1));
          end else begin
            idx_d           = take_k;
            mem_req_o.raddr = AW'(take_k);
          end
        end
      end
      S_SHIFT_UP: begin
        // Move the entry below up by one, or drop the new one in here.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AW'(idx_q);
        if (ins_stop) begin
          mem_req_o.wdata = new_q;
          count_d         = count_q + CW'(1);
          done_d          = 1'b1;
          res_pos_d       = idx_pos;
          res_count_d     = PW'(count_q + CW'(1));
        end else begin
          mem_req_o.wdata = mem_rdata_i;
          idx_d           = idx_dec;
          mem_req_o.raddr = AW'(idx_q - CW'(2));
        end
      end
      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AW'(idx_q);
        mem_req_o.wdata = new_q;
        count_d         = count_q + CW'(1);
        done_d          = 1'b1;
        res_pos_d       = idx_pos;
        res_count_d     = PW'(count_q + CW'(1));
      end
      S_TAKE: begin
        res_d     = mem_rdata_i;
        res_pos_d = idx_pos;
        if (cmd_q == CMD_READ) begin
          done_d      = 1'b1;
          res_count_d = PW'(count_q);
        end else if (last_take) begin
          count_d     = count_q - CW'(1);
          done_d      = 1'b1;
          res_count_d = PW'(count_q - CW'(1));
        end else begin
          mem_req_o.raddr = AW'(idx_inc);
        end
      end
      S_SHIFT_DN: begin
        // Close the gap: move the entry above down by one.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AW'(idx_q);
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_inc;
        if (last_dn) begin
          count_d     = count_q - CW'(1);
          done_d      = 1'b1;
          res_count_d = PW'(count_q - CW'(1));
        end else begin
          mem_req_o.raddr = AW'(idx_q + CW'(2));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    new_q       <= new_d;
    lim_q       <= lim_d;
    idx_q       <= idx_d;
    status_q    <= status_d;
    res_q       <= res_d;
    res_pos_q   <= res_pos_d;
    res_count_q <= res_count_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_value_o    = res_q.value;
  assign out_element_o  = res_q.element;
  assign out_position_o = res_pos_q;
  assign entry_count_o  = res_count_q;

endmodule

`default_nettype wire

>>> src/ordered_list_engine.sv
`default_nettype none

// Ordered list of up to 16 entries (signed value and tag), one command per
// request. A request is taken when start is high and busy is low. Its single
// result appears for exactly one cycle with done_o high, in the first cycle
// with busy low again. It must be captured then, since the receiver cannot
// stall it. Rejected commands answer in the cycle after the request, and busy
// never rises for them. A command that moves entries keeps busy high while
// they shift, and up to fifteen entries shift. The entry store has one read
// port and one write port, so the shift walks one slot per cycle.
// descending_mode is written through the cfg_valid_i/cfg_ready_o channel;
// the user must write it only while the block is idle, since the block
// itself does not enforce this.
module ordered_list_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_i,
  input  logic [31:0]        element_i,
  input  logic [4:0]         position_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic [31:0]        out_element_o,
  output logic [4:0]         out_position_o,
  output logic [4:0]         entry_count_o
);
  import ole_pkg::*;

  logic     mode_q;
  mem_req_t mem_req;
  entry_t   mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  ole_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_q),
    .command_i      (command_i),
    .value_i        (value_i),
    .element_i      (element_i),
    .position_i     (position_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_element_o  (out_element_o),
    .out_position_o (out_position_o),
    .entry_count_o  (entry_count_o)
  );

  ole_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

>>> src/ole_checker.sv
`default_nettype none

`include "ordered_list_engine_macros.svh"

module ole_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               cfg_data_i,
  input logic               start,
  input logic               busy,
  input logic [2:0]         command_i,
  input logic signed [31:0] value_i,
  input logic [31:0]        element_i,
  input logic [4:0]         position_i,
  input logic               done_o,
  input logic [2:0]         status_o,
  input logic signed [31:0] out_value_o,
  input logic [31:0]        out_element_o,
  input logic [4:0]         out_position_o,
  input logic [4:0]         entry_count_o
);
  import ole_pkg::*;

  // A taken request either starts work or answers right away.
  `OLE_ASSERT_NEXT(a_req_progress, clk_i, rst_ni, start && !busy, busy || done_o)

  // A failed command returns no entry data.
  `OLE_ASSERT_SAME(a_fail_zero, clk_i, rst_ni, done_o && (status_o != ST_OK), (out_value_o == '0) && (out_element_o == '0) && (out_position_o == '0))

  // A good command names a real slot.
  `OLE_ASSERT_SAME(a_ok_pos, clk_i, rst_ni, done_o && (status_o == ST_OK), (out_position_o != '0) && ({1'b0, out_position_o} <= ({1'b0, entry_count_o} + 6'd1)))

  // Full is reported only with a full list.
  `OLE_ASSERT_SAME(a_full_count, clk_i, rst_ni, done_o && (status_o == ST_FULL), 32'(entry_count_o) == 32'(CAPACITY))

endmodule

bind ordered_list_engine ole_checker u_checker (.*);

`default_nettype wire

>>> tb/ordered_list_engine_tb.sv
`default_nettype none

module ordered_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ole_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES = 8;

  typedef struct {
    cmd_e                cmd;
    logic signed [31:0]  value;
    logic [31:0]         element;
    logic [4:0]          position;
  } list_cmd_t;

  typedef struct {
    status_e             status;
    logic signed [31:0]  value;
    logic [31:0]         element;
    logic [4:0]          position;
    logic [4:0]          count;
  } list_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         command_i = '0;
  logic signed [31:0] value_i = '0;
  logic [31:0]        element_i = '0;
  logic [4:0]         position_i = '0;
  logic               done_o;
  logic [2:0]         status_o;
  logic signed [31:0] out_value_o;
  logic [31:0]        out_element_o;
  logic [4:0]         out_position_o;
  logic [4:0]         entry_count_o;

  // shadow of the list as the block should hold it
  logic signed [31:0] list_vals [CAPACITY];
  logic [31:0]        list_tags [CAPACITY];
  int                 list_len = 0;
  bit                 desc_mode = 1'b0;

  list_cmd_t   cmd_backlog [$];
  list_reply_t due_replies [$];
  list_cmd_t   cur_req;
  bit          calm_run = 1'b0;
  int          mismatches = 0;
  int          stall_cycles = 0;

  ordered_list_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .value_i        (value_i),
    .element_i      (element_i),
    .position_i     (position_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_element_o  (out_element_o),
    .out_position_o (out_position_o),
    .entry_count_o  (entry_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic list_reply_t apply_list_command(list_cmd_t c);
    list_reply_t r;
    int          k;
    int          pos;
    bit          do_put;
    bit          do_take;
    r.status   = ST_OK;
    r.value    = '0;
    r.element  = '0;
    r.position = '0;
    k          = 0;
    pos        = int'(c.position);
    do_put     = 1'b0;
    do_take    = 1'b0;
    if (c.cmd <= CMD_INSERT_AFTER) begin
      // mode is checked ahead of capacity
      if (desc_mode != (c.cmd == CMD_SORTED)) begin
        r.status = ST_MODE;
      end else if (list_len >= int'(CAPACITY)) begin
        r.status = ST_FULL;
      end else begin
        do_put = 1'b1;
        case (c.cmd)
          CMD_SORTED: begin
            // equal values stay ahead of the new entry
            k = list_len;
            while (k > 0 && !(c.value <= list_vals[k-1])) k--;
          end
          CMD_PUSH_BACK:  k = list_len;
          CMD_PUSH_FRONT: k = 0;
          default: begin
            if (pos > list_len) begin
              r.status = ST_NOPOS;
              do_put   = 1'b0;
            end else begin
              k = pos;
            end
          end
        endcase
      end
    end else if (list_len == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (c.cmd)
        CMD_POP_BACK:  k = list_len - 1;
        CMD_POP_FRONT: k = 0;
        default:       k = (pos == 0 || pos > list_len) ? int'(CAPACITY) : pos - 1;
      endcase
      if (k >= list_len) begin
        r.status = ST_NOPOS;
      end else begin
        r.value    = list_vals[k];
        r.element  = list_tags[k];
        r.position = 5'(k + 1);
        do_take    = (c.cmd != CMD_READ);
      end
    end
    if (do_put) begin
      for (int i = list_len; i > k; i--) begin
        list_vals[i] = list_vals[i-1];
        list_tags[i] = list_tags[i-1];
      end
      list_vals[k] = c.value;
      list_tags[k] = c.element;
      list_len++;
      r.position = 5'(k + 1);
    end
    if (do_take) begin
      for (int i = k; i + 1 < list_len; i++) begin
        list_vals[i] = list_vals[i+1];
        list_tags[i] = list_tags[i+1];
      end
      list_len--;
    end
    r.count = 5'(list_len);
    return r;
  endfunction

  // request driver: holds a request until the block takes it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) due_replies.push_back(apply_list_command(cur_req));
      if (!start || !busy) begin
        if (cmd_backlog.size() != 0 && (calm_run || $urandom_range(0, 99) >= 7)) begin
          cur_req = cmd_backlog.pop_front();
          start      <= 1'b1;
          command_i  <= cur_req.cmd;
          value_i    <= cur_req.value;
          element_i  <= cur_req.element;
          position_i <= cur_req.position;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobe must match the oldest pending reply
  always @(posedge clk_i) begin
    list_reply_t exp_r;
    if (rst_ni && done_o) begin
      if (due_replies.size() == 0) begin
        $display("%0t: result with none pending: status %0d value %0d element %h",
                 $time, status_o, out_value_o, out_element_o);
        mismatches++;
      end else begin
        exp_r = due_replies.pop_front();
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, exp_r.status, status_o);
          mismatches++;
        end
        if (out_value_o !== exp_r.value) begin
          $display("%0t: out_value expected %0d, actual %0d", $time, exp_r.value,
                   out_value_o);
          mismatches++;
        end
        if (out_element_o !== exp_r.element) begin
          $display("%0t: out_element expected %h, actual %h", $time, exp_r.element,
                   out_element_o);
          mismatches++;
        end
        if (out_position_o !== exp_r.position) begin
          $display("%0t: out_position expected %0d, actual %0d", $time, exp_r.position,
                   out_position_o);
          mismatches++;
        end
        if (entry_count_o !== exp_r.count) begin
          $display("%0t: entry_count expected %0d, actual %0d", $time, exp_r.count,
                   entry_count_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request, result or register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cycles);
        $display("ordered_list_engine regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_cmd(cmd_e c, logic signed [31:0] v, logic [31:0] e, logic [4:0] p);
    list_cmd_t item;
    item.cmd      = c;
    item.value    = v;
    item.element  = e;
    item.position = p;
    cmd_backlog.push_back(item);
  endtask

  task automatic write_mode(bit m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    desc_mode = m;
  endtask

  // wait until every request is taken and answered, then let the block settle
  task automatic drain;
    do @(negedge clk_i); while (cmd_backlog.size() != 0 || start || due_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_random_phase(int n, bit m);
    int                 fill_pct;
    int                 roll;
    int                 sel;
    cmd_e               c;
    logic signed [31:0] v;
    logic [4:0]         p;
    fill_pct = 50;
    for (int i = 0; i < n; i++) begin
      // swing between growing and shrinking so both full and empty are hit
      if (i % 20 == 0) begin
        sel = $urandom_range(0, 2);
        fill_pct = (sel == 0) ? 80 : (sel == 1) ? 50 : 20;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        c = m ? cmd_e'($urandom_range(1, 3)) : CMD_SORTED;
      end else if (roll < fill_pct) begin
        c = m ? CMD_SORTED : cmd_e'($urandom_range(1, 3));
      end else begin
        c = cmd_e'($urandom_range(4, 7));
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7fff_ffff;
        2, 3, 4: v = $signed($urandom_range(0, 4)) - 2;
        default: v = $urandom;
      endcase
      p = 5'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 17) : $urandom_range(0, 31));
      queue_cmd(c, v, $urandom, p);
    end
  endtask

  initial begin
    logic signed [31:0] sorted_seed [16];
    sorted_seed = '{5, 5, -3, 32'sh7fff_ffff, 32'sh8000_0000, 0, 5, 0,
                    -3, 32'sh7fff_ffff, 1, 32'sh8000_0000, 5, -1, 0, 2};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(1'b0);
    queue_cmd(CMD_POP_FRONT, 0, 0, 0);
    queue_cmd(CMD_REMOVE, 0, 0, 0);
    queue_cmd(CMD_SORTED, 7, 32'h1, 0);
    queue_cmd(CMD_INSERT_AFTER, 1, 32'h2, 1);
    queue_cmd(CMD_INSERT_AFTER, 32'sh7fff_ffff, 32'hffff_ffff, 0);
    queue_cmd(CMD_PUSH_FRONT, 32'sh8000_0000, 32'h0, 0);
    queue_cmd(CMD_PUSH_BACK, 0, 32'h5a5a_a5a5, 0);
    queue_cmd(CMD_READ, 0, 0, 0);
    queue_cmd(CMD_REMOVE, 0, 0, 31);
    queue_cmd(CMD_REMOVE, 0, 0, 2);
    queue_cmd(CMD_POP_BACK, 0, 0, 0);
    queue_cmd(CMD_POP_FRONT, 0, 0, 0);
    drain();

    write_mode(1'b1);
    queue_cmd(CMD_PUSH_BACK, 3, 32'h3, 0);
    // fill with repeated values; tags show where each equal entry landed
    for (int i = 0; i < 16; i++) queue_cmd(CMD_SORTED, sorted_seed[i], i, 0);
    queue_cmd(CMD_SORTED, 4, 32'hdead_0001, 0);
    queue_cmd(CMD_PUSH_FRONT, 4, 32'hdead_0002, 0);
    queue_cmd(CMD_READ, 0, 0, 16);
    queue_cmd(CMD_POP_BACK, 0, 0, 0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(1'(ph % 2));
      calm_run = (ph == 3);
      queue_random_phase(PHASE_ITEMS, 1'(ph % 2));
      drain();
    end

    if (mismatches == 0) begin
      $display("ordered_list_engine regression: pass");
    end else begin
      $display("ordered_list_engine regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
